>>> rtl/cqe_pkg.sv
// ----------------------------------------------------------------------------
// cqe_pkg
// Shared types and codes of the circular queue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqe_pkg;

   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request opcodes. The fourth code is ignored.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DISPLAY = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ_READ,
      ST_DISP_WALK
   } state_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] data_out;
      logic                     last_flag;
   } rsp_type;

endpackage

>>> rtl/cqe_req_if.sv
// ----------------------------------------------------------------------------
// cqe_req_if
// Request channel: opcode and word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cqe_req_if;
   import cqe_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic signed [WORD_W-1:0] item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);

endinterface

>>> rtl/cqe_rsp_if.sv
// ----------------------------------------------------------------------------
// cqe_rsp_if
// Response channel: status, word and last marker with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cqe_rsp_if;
   import cqe_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [WORD_W-1:0] data_out;
   logic                     last_flag;

   modport source (output valid, output status, output data_out, output last_flag,
                   input ready);
   modport sink   (input valid, input status, input data_out, input last_flag,
                   output ready);

endinterface

>>> rtl/cqe_rsp_buf.sv
// ----------------------------------------------------------------------------
// cqe_rsp_buf
// Two-entry output queue that decouples the engine from the response sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqe_rsp_buf (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cqe_pkg::rsp_type push_data,
   output logic            full,
   cqe_rsp_if.source       rsp_ch
);
   import cqe_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   rsp_type    head_entry;

   assign full       = (count_ff == 2'd2);
   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign head_entry = entry_ff[rd_ptr_ff];

   assign rsp_ch.valid     = (count_ff != 2'd0);
   assign rsp_ch.status    = head_entry.status;
   assign rsp_ch.data_out  = head_entry.data_out;
   assign rsp_ch.last_flag = head_entry.last_flag;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("response pushed into a full output queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("output queue pointers disagree with count");

endmodule

>>> rtl/circular_queue_engine.sv
// ----------------------------------------------------------------------------
// circular_queue_engine
// Enqueue, overflow, underflow, empty display: result in the cycle after accept.
// Dequeue: the slot is read into rd_data_ff, then pushed; next item taken back in idle.
// Display of n words: n results, one per cycle while the output queue is not full,
// next item taken once the last result is pushed; the slot RAM has a single read port.
// Reset (synchronous): queue empty, pointers 0, capacity 16; slot RAM not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_queue_engine #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   cqe_req_if.sink                   req_ch,
   cqe_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [cqe_pkg::CAP_W-1:0] csr_wr_data
);
   import cqe_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = IW + 1;
   localparam int RW = (CW > CAP_W) ? CW : CAP_W;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [IW-1:0]     tail_ff, tail_in;
   logic [IW-1:0]     walk_ff, walk_in;
   logic              empty_ff, empty_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;

   logic [RW-1:0]     raw_cap;
   logic [CW-1:0]     eff_cap;
   logic              q_full;
   logic              accept;
   logic              buf_full;
   logic              push;
   rsp_type           push_data;
   logic              wr_en;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     walk_next;
   logic              walk_last;

   function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] n;
      n = {1'b0, idx} + CW'(1);
      return (n >= cap) ? '0 : n[IW-1:0];
   endfunction

   // A stored value of zero acts as one, and anything above DEPTH saturates.
   always_comb begin
      raw_cap = RW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (raw_cap > RW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(raw_cap);
      end
   end

   assign q_full       = !empty_ff && (head_ff == tail_ff);
   assign req_ch.ready = (state_ff == ST_IDLE) && !buf_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign walk_next    = advance(walk_ff, eff_cap);
   assign walk_last    = (walk_next == tail_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !empty_ff && req_ch.opcode == OP_DEQUEUE) begin
               state_in = ST_DEQ_READ;
            end else if (accept && !empty_ff && req_ch.opcode == OP_DISPLAY) begin
               state_in = ST_DISP_WALK;
            end
         end
         ST_DEQ_READ: begin
            if (!buf_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_DISP_WALK: begin
            if (!buf_full && walk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and queue state updates.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      walk_in   = walk_ff;
      cap_in    = cap_ff;
      push      = 1'b0;
      push_data = '{status: STATUS_OK, data_out: '0, last_flag: 1'b1};
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.opcode)
                  OP_ENQUEUE: begin
                     push = 1'b1;
                     if (q_full) begin
                        push_data.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = advance(tail_ff, eff_cap);
                        empty_in = 1'b0;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (empty_ff) begin
                        push             = 1'b1;
                        push_data.status = STATUS_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        head_in  = advance(head_ff, eff_cap);
                        empty_in = (advance(head_ff, eff_cap) == tail_ff);
                     end
                  end
                  OP_DISPLAY: begin
                     if (empty_ff) begin
                        push             = 1'b1;
                        push_data.status = STATUS_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        walk_in = head_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DEQ_READ: begin
            if (!buf_full) begin
               push               = 1'b1;
               push_data.data_out = rd_data_ff;
            end
         end
         ST_DISP_WALK: begin
            if (!buf_full) begin
               push                = 1'b1;
               push_data.data_out  = rd_data_ff;
               push_data.last_flag = walk_last;
               if (!walk_last) begin
                  rd_en   = 1'b1;
                  rd_addr = walk_next;
                  walk_in = walk_next;
               end
            end
         end
         default: ;
      endcase

      // A capacity write empties the queue; the user must write it only while idle, the block does not enforce this.
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         walk_ff  <= '0;
         empty_ff <= 1'b1;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         walk_ff  <= walk_in;
         empty_ff <= empty_in;
         cap_ff   <= cap_in;
      end
   end

   // Slot RAM. A read of a slot always comes in a later cycle than its write
   // because only one item is in flight, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= req_ch.item_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   cqe_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (buf_full),
      .rsp_ch    (rsp_ch)
   );

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < eff_cap) && ({1'b0, tail_ff} < eff_cap))
      else $error("queue pointer beyond capacity in use");

   a_deq_read: assert property (@(posedge clock) disable iff (reset)
      (accept && !empty_ff && req_ch.opcode == OP_DEQUEUE) |=> (state_ff == ST_DEQ_READ))
      else $error("dequeue did not start a slot read");

   a_walk_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP_WALK && !buf_full && !walk_last) |=>
         (state_ff == ST_DISP_WALK && walk_ff == $past(walk_next)))
      else $error("display walk lost its position");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular queue engine. A shadow copy of the
// queue predicts every response from the accepted requests. Directed tests
// cover the empty, full and wraparound cases and the capacity corner values.
// Random traffic then runs under several capacities and settings of sender
// gaps and receiver stalls; one directed test adds a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import cqe_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int MAX_PRINTED = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   cqe_req_if req_if ();
   cqe_rsp_if rsp_if ();

   circular_queue_engine #(.DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the queue, updated on every accepted request.
   logic signed [WORD_W-1:0] shadow_slots [DEPTH];
   int unsigned shadow_head;
   int unsigned shadow_tail;
   bit shadow_empty;
   logic [CAP_W-1:0] shadow_cap;
   rsp_type awaited_rsp [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int hold_left;
   int error_count;
   int printed_errors;
   int results_checked;
   int idle_cycles;
   int stalled_input_cycles;
   int capacity_writes;
   int ops_sent [4];
   int overflow_seen;
   int underflow_seen;
   int empty_seen;

   function automatic int unsigned effective_capacity();
      if (shadow_cap == 0) return 1;
      if (shadow_cap > DEPTH) return DEPTH;
      return 32'(shadow_cap);
   endfunction

   function automatic int unsigned next_slot(input int unsigned idx, input int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
   endfunction

   function automatic void expect_result(input logic [1:0] status,
                                         input logic signed [WORD_W-1:0] data,
                                         input logic last);
      rsp_type r;
      r.status    = status;
      r.data_out  = data;
      r.last_flag = last;
      awaited_rsp.push_back(r);
   endfunction

   function automatic void predict_queue_op(input logic [1:0] op,
                                            input logic signed [WORD_W-1:0] value);
      int unsigned cap;
      int unsigned idx;
      int unsigned nxt;
      int count;
      bit full;
      cap  = effective_capacity();
      full = !shadow_empty && shadow_head == shadow_tail;
      case (op)
         OP_ENQUEUE: begin
            if (full) begin
               overflow_seen++;
               expect_result(STATUS_OVERFLOW, '0, 1'b1);
            end else begin
               shadow_slots[shadow_tail] = value;
               shadow_tail  = next_slot(shadow_tail, cap);
               shadow_empty = 1'b0;
               expect_result(STATUS_OK, '0, 1'b1);
            end
         end
         OP_DEQUEUE: begin
            if (shadow_empty) begin
               underflow_seen++;
               expect_result(STATUS_UNDERFLOW, '0, 1'b1);
            end else begin
               expect_result(STATUS_OK, shadow_slots[shadow_head], 1'b1);
               shadow_head = next_slot(shadow_head, cap);
               if (shadow_head == shadow_tail) shadow_empty = 1'b1;
            end
         end
         OP_DISPLAY: begin
            if (shadow_empty) begin
               empty_seen++;
               expect_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               idx   = shadow_head;
               count = 0;
               do begin
                  nxt = next_slot(idx, cap);
                  expect_result(STATUS_OK, shadow_slots[idx], nxt == shadow_tail);
                  count++;
                  idx = nxt;
               end while (idx != shadow_tail && count < DEPTH);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (printed_errors < MAX_PRINTED) begin
         printed_errors++;
         $display("%0t ns ERROR: %s", $realtime, msg);
      end
   endtask

   // The receiver stalls at random, or holds off entirely when a test asks.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request <= 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < recv_stall_pct) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: status %0d data %h",
                                      rsp_if.status, rsp_if.data_out));
         end else begin
            want = awaited_rsp.pop_front();
            results_checked++;
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_if.status, want.status));
            if (rsp_if.data_out !== want.data_out)
               report_mismatch($sformatf("data_out got %h want %h",
                                         rsp_if.data_out, want.data_out));
            if (rsp_if.last_flag !== want.last_flag)
               report_mismatch($sformatf("last_flag got %b want %b",
                                         rsp_if.last_flag, want.last_flag));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (req_if.valid && !req_if.ready && !rsp_if.ready) stalled_input_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic signed [WORD_W-1:0] value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opcode     <= op;
      req_if.item_value <= value;
      do @(posedge clock); while (!req_if.ready);
      ops_sent[op]++;
      predict_queue_op(op, value);
   endtask

   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A capacity write also empties the queue.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shadow_cap   = value;
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_empty = 1'b1;
      capacity_writes++;
   endtask

   task automatic test_reset_state_and_extremes();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item(OP_DISPLAY, WORD_MAX);
      send_item(OP_DEQUEUE, WORD_MIN);
      send_item(OP_IGNORED, -1);
      send_item(OP_ENQUEUE, WORD_MAX);
      send_item(OP_ENQUEUE, WORD_MIN);
      send_item(OP_ENQUEUE, 0);
      send_item(OP_ENQUEUE, -1);
      send_item(OP_ENQUEUE, 32'sh5555_aaaa);
      send_item(OP_DISPLAY, 0);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_DEQUEUE, 0);
   endtask

   // Capacity two: the pointers wrap and the queue is filled, overflowed and drained.
   task automatic test_two_slot_wraparound();
      write_capacity(5'd2);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_DISPLAY, 0);
      send_item(OP_ENQUEUE, 32'sh1234_5678);
      send_item(OP_ENQUEUE, 32'shedcb_a987);
      send_item(OP_ENQUEUE, WORD_MAX);
      send_item(OP_DISPLAY, 0);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_ENQUEUE, 32'sh0f0f_f0f0);
      send_item(OP_DISPLAY, 0);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_DEQUEUE, 0);
      send_item(OP_DEQUEUE, 0);
   endtask

   // The receiver holds off while a full queue's worth of requests is offered.
   task automatic test_backpressure_fill();
      write_capacity(5'd16);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request <= HOLD_OFF_CYCLES;
      for (int i = 0; i < DEPTH; i++) send_item(OP_ENQUEUE, $urandom);
      send_item(OP_ENQUEUE, WORD_MIN);
      send_item(OP_DISPLAY, 0);
      for (int i = 0; i < DEPTH; i++) send_item(OP_DEQUEUE, $urandom);
      send_item(OP_DISPLAY, 0);
   endtask

   task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int n_items,
                                      input int send_pct, input int stall_pct);
      logic [1:0] op;
      logic signed [WORD_W-1:0] value;
      int pick;
      int burst_left;
      bit filling;
      write_capacity(cap);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      filling    = 1'b1;
      burst_left = $urandom_range(28, 8);
      for (int i = 0; i < n_items; i++) begin
         // Alternate fill-heavy and drain-heavy bursts so the queue swings
         // between empty and full.
         if (burst_left == 0) begin
            filling    = !filling;
            burst_left = $urandom_range(28, 8);
         end
         burst_left--;
         pick = $urandom_range(99, 0);
         if (pick >= 95)
            op = OP_IGNORED;
         else if (pick >= 85)
            op = OP_DISPLAY;
         else if ((pick < 75) == filling)
            op = OP_ENQUEUE;
         else
            op = OP_DEQUEUE;
         case ($urandom_range(7, 0))
            0: value = WORD_MAX;
            1: value = WORD_MIN;
            2: value = -1;
            3: value = 0;
            default: value = $urandom;
         endcase
         send_item(op, value);
      end
   endtask

   initial begin
      csr_wr_en         = 1'b0;
      csr_wr_data       = CAP_RESET;
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_ENQUEUE;
      req_if.item_value = '0;
      rsp_if.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      shadow_cap   = CAP_RESET;
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_empty = 1'b1;

      test_reset_state_and_extremes();
      test_two_slot_wraparound();
      test_backpressure_fill();
      test_random_traffic(5'd16, 36, 0, 0);
      test_random_traffic(5'd1, 30, 50, 0);
      test_random_traffic(5'd0, 30, 0, 50);
      test_random_traffic(5'd31, 36, 8, 8);
      test_random_traffic(5'd17, 32, 0, 0);
      test_random_traffic(5'd5, 32, 50, 0);
      test_random_traffic(CAP_W'($urandom_range(16, 1)), 32, 0, 50);
      test_random_traffic(5'd3, 32, 8, 8);

      wait_until_drained();
      repeat (DEPTH + 4) @(posedge clock);
      $display("Requests: %0d enqueue, %0d dequeue, %0d display, %0d ignored",
               ops_sent[OP_ENQUEUE], ops_sent[OP_DEQUEUE], ops_sent[OP_DISPLAY],
               ops_sent[OP_IGNORED]);
      $display("Results checked %0d; overflows %0d, underflows %0d, empty displays %0d",
               results_checked, overflow_seen, underflow_seen, empty_seen);
      $display("Capacity writes %0d, %0d stalled input cycles",
               capacity_writes, stalled_input_cycles);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
